>>> rtl/ird_pkg.sv
package ird_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_COMMIT,
    ST_EMIT
  } ird_state_t;

  localparam logic [3:0] OP_RAISE    = 4'd0;
  localparam logic [3:0] OP_CLEAR    = 4'd1;
  localparam logic [3:0] OP_EOI      = 4'd2;
  localparam logic [3:0] OP_SET_RT   = 4'd3;
  localparam logic [3:0] OP_SET_EN   = 4'd4;
  localparam logic [3:0] OP_EN_LINES = 4'd5;
  localparam logic [3:0] OP_DIS_LINES = 4'd6;
  localparam logic [3:0] OP_PROG_RST = 4'd7;
  localparam logic [3:0] OP_GET_RT   = 4'd8;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_RAISE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_RESET  = 2'd3;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk;
    logic commit;
    logic emit;
  } ird_cmd_t;

  typedef struct packed {
    logic dmask_any;
    logic walk_done;
    logic emit_last;
  } ird_sts_t;

endpackage

>>> rtl/ird_ctrl.sv
module ird_ctrl
  import ird_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ird_sts_t sts,
  output ird_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  ird_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.dmask_any ? ST_WALK : ST_EMIT;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        out_valid = 1'b1;
        if (sts.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/ird_datapath.sv
module ird_datapath
  import ird_pkg::*;
#(
  parameter int LINES          = 64,
  parameter int EXTERNAL_LINES = 32,
  parameter int MAX_TARGETS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ird_cmd_t    cmd,
  output ird_sts_t    sts,
  input  logic [3:0]  in_op,
  input  logic [5:0]  in_line,
  input  logic [2:0]  in_target_index,
  input  logic [63:0] in_mask,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_ok,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_target,
  output logic [5:0]  out_line_res,
  output logic [2:0]  out_route_value,
  output logic [31:0] out_enabled_now,
  output logic [31:0] out_pending_now,
  output logic [31:0] out_active_now,
  output logic        out_last
);

  localparam int          WLN = (EXTERNAL_LINES > 64) ? 64 : EXTERNAL_LINES;
  localparam int          CW  = $clog2(WLN + 1);
  localparam logic [63:0] EXT_MASK = (WLN >= 64) ? {64{1'b1}} :
                                     ((64'd1 << WLN) - 64'd1);

  logic [2:0]  mem [64];
  logic [63:0] vld_r;
  logic [2:0]  rd_q;
  logic [5:0]  rd_addr_r;
  logic [5:0]  rd_addr;
  logic        mem_we;

  logic [3:0]  tc_r;
  logic [3:0]  eff;
  logic [3:0]  op_r;
  logic [5:0]  ln_r;
  logic [2:0]  ti_r;
  logic [63:0] mask_r;

  logic [63:0] pend_r, en_r, act_r;
  logic        prog_r;
  logic        ok_r;
  logic [2:0]  rv_r;
  logic [1:0]  fk_r;
  logic [2:0]  ft_r;
  logic [5:0]  fl_r;
  logic [MAX_TARGETS-1:0] dmask_r, found_r, blk_r, dlv_r;
  logic [5:0]  dline_r [MAX_TARGETS];

  logic [CW-1:0] cnt_r;
  logic          ev_v_r;
  logic [5:0]    ev_ln_r;

  logic [2:0]  r;
  logic [63:0] bit_m;
  logic        inr, ext, r_ok, ti_ok, abit;
  logic        set_ok, mask_bad;
  logic [MAX_TARGETS-1:0] dmask_nxt, all_t, rbit, tibit;

  assign eff = (tc_r > 4'(MAX_TARGETS)) ? 4'(MAX_TARGETS) : tc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= 4'd1;
    end else if (cfg_we) begin
      tc_r <= cfg_wdata;
    end
  end

  assign set_ok   = inr && ti_ok && !(prog_r && (!ext || abit));
  assign mask_bad = |(mask_r & ~EXT_MASK);

  assign rd_addr = cmd.latch ? in_line : 6'(cnt_r);
  assign mem_we  = cmd.exec && op_r == OP_SET_RT && set_ok;

  always_ff @(posedge clk) begin
    if (mem_we) mem[ln_r] <= ti_r;
    rd_q      <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  assign r     = vld_r[rd_addr_r] ? rd_q : 3'd0;
  assign bit_m = 64'd1 << ln_r;
  assign inr   = 32'(ln_r) < LINES;
  assign ext   = 32'(ln_r) < WLN;
  assign r_ok  = {1'b0, r} < eff;
  assign ti_ok = {1'b0, ti_r} < eff;
  assign abit  = |(act_r & bit_m);

  always_comb begin
    for (int t = 0; t < MAX_TARGETS; t++) begin
      all_t[t] = 4'(t) < eff;
      rbit[t]  = (3'(t) == r) && r_ok;
      tibit[t] = (3'(t) == ti_r);
    end
  end

  always_comb begin
    dmask_nxt = '0;
    case (op_r)
      OP_RAISE:  if (inr && prog_r && ext && !abit) dmask_nxt = rbit;
      OP_CLEAR:  if (inr && prog_r && ext && abit) dmask_nxt = rbit;
      OP_EOI:    if (ext && prog_r && abit) dmask_nxt = rbit;
      OP_SET_RT: if (set_ok && prog_r) dmask_nxt = tibit;
      OP_SET_EN, OP_EN_LINES:
        if (!mask_bad && prog_r) dmask_nxt = all_t;
      default:   dmask_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      pend_r <= '0;
      en_r   <= '1;
      act_r  <= '0;
      prog_r <= 1'b0;
      cnt_r  <= '0;
      ev_v_r <= 1'b0;
      dlv_r  <= '0;
      fk_r   <= KIND_STATUS;
    end else begin
      if (cmd.latch) begin
        op_r   <= in_op;
        ln_r   <= in_line;
        ti_r   <= in_target_index;
        mask_r <= in_mask;
      end
      if (cmd.exec) begin
        ok_r    <= 1'b0;
        rv_r    <= 3'd0;
        fk_r    <= KIND_STATUS;
        ft_r    <= r;
        fl_r    <= ln_r;
        dmask_r <= dmask_nxt;
        found_r <= '0;
        blk_r   <= '0;
        dlv_r   <= '0;
        cnt_r   <= '0;
        ev_v_r  <= 1'b0;
        case (op_r)
          OP_RAISE: begin
            if (inr && !prog_r && r_ok) begin
              ok_r <= 1'b1;
              fk_r <= KIND_RAISE;
            end else if (inr && prog_r && ext) begin
              ok_r   <= 1'b1;
              pend_r <= pend_r | bit_m;
            end
          end
          OP_CLEAR: begin
            if (inr && !prog_r && r_ok) begin
              ok_r <= 1'b1;
              fk_r <= KIND_CLEAR;
            end else if (inr && prog_r && ext) begin
              ok_r   <= 1'b1;
              pend_r <= pend_r & ~bit_m;
              if (abit) begin
                act_r <= act_r & ~bit_m;
                if (r_ok) fk_r <= KIND_CLEAR;
              end
            end
          end
          OP_EOI: begin
            if (ext && prog_r && abit) begin
              ok_r  <= 1'b1;
              act_r <= act_r & ~bit_m;
            end
          end
          OP_SET_RT: begin
            if (set_ok) begin
              ok_r         <= 1'b1;
              vld_r[ln_r]  <= 1'b1;
            end
          end
          OP_SET_EN, OP_EN_LINES, OP_DIS_LINES: begin
            if (!mask_bad && prog_r) begin
              ok_r <= 1'b1;
              if (op_r == OP_SET_EN) en_r <= mask_r;
              else if (op_r == OP_EN_LINES) en_r <= en_r | mask_r;
              else en_r <= en_r & ~mask_r;
            end
          end
          OP_PROG_RST: begin
            ok_r   <= 1'b1;
            prog_r <= 1'b1;
            en_r   <= '0;
            pend_r <= '0;
            act_r  <= '0;
            vld_r  <= '0;
            fk_r   <= KIND_RESET;
            ft_r   <= 3'd0;
            fl_r   <= 6'd0;
          end
          OP_GET_RT: begin
            if (ext) begin
              ok_r <= 1'b1;
              rv_r <= r;
            end
          end
          default: ok_r <= 1'b0;
        endcase
      end
      if (cmd.walk) begin
        if (cnt_r < CW'(WLN)) begin
          cnt_r   <= cnt_r + 1'b1;
          ev_v_r  <= 1'b1;
          ev_ln_r <= 6'(cnt_r);
        end else begin
          ev_v_r <= 1'b0;
        end
        if (ev_v_r) begin
          for (int t = 0; t < MAX_TARGETS; t++) begin
            if (r == 3'(t)) begin
              if (act_r[ev_ln_r]) blk_r[t] <= 1'b1;
              if (pend_r[ev_ln_r] && en_r[ev_ln_r] && !found_r[t]) begin
                found_r[t]   <= 1'b1;
                dline_r[t]   <= ev_ln_r;
              end
            end
          end
        end
      end
      if (cmd.commit) begin
        dlv_r <= found_r & ~blk_r & dmask_r;
        for (int t = 0; t < MAX_TARGETS; t++) begin
          if (found_r[t] && !blk_r[t] && dmask_r[t]) begin
            pend_r[dline_r[t]] <= 1'b0;
            act_r[dline_r[t]]  <= 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        if (fk_r != KIND_STATUS) fk_r <= KIND_STATUS;
        else dlv_r <= dlv_r & (dlv_r - 1'b1);
      end
    end
  end

  logic [2:0] lo_t;
  always_comb begin
    lo_t = 3'd0;
    for (int t = MAX_TARGETS - 1; t >= 0; t--) begin
      if (dlv_r[t]) lo_t = 3'(t);
    end
  end

  always_comb begin
    out_ok          = ok_r;
    out_route_value = rv_r;
    out_enabled_now = en_r[31:0];
    out_pending_now = pend_r[31:0];
    out_active_now  = act_r[31:0];
    if (fk_r != KIND_STATUS) begin
      out_kind     = fk_r;
      out_target   = ft_r;
      out_line_res = fl_r;
      out_last     = (dlv_r == '0);
    end else if (dlv_r != '0) begin
      out_kind     = KIND_RAISE;
      out_target   = lo_t;
      out_line_res = dline_r[lo_t];
      out_last     = ((dlv_r & (dlv_r - 1'b1)) == '0);
    end else begin
      out_kind     = KIND_STATUS;
      out_target   = 3'd0;
      out_line_res = 6'd0;
      out_last     = 1'b1;
    end
  end

  assign sts.dmask_any = |dmask_nxt;
  assign sts.walk_done = (cnt_r == CW'(WLN)) && !ev_v_r;
  assign sts.emit_last = out_last;

endmodule

>>> rtl/interrupt_router_dispatch_core.sv
// channel  ports                                          handshake
// in       in_op in_line in_target_index in_mask          start & !busy
// out      out_ok out_kind out_target out_line_res ...    out_valid, one cycle
// cfg      cfg_wdata (hart count)                         cfg_we
// An item is latched, executed, then emitted at one result per cycle; ops that
// redispatch add a walk of the route table memory and a commit before the emit.
// Results follow back to back, out_last on the final beat; busy falls after it.
// Synchronous active-low reset clears pending, active, route valid bits.
// The receiver cannot stall; a beat is taken in the cycle it is shown.
module interrupt_router_dispatch_core
  import ird_pkg::*;
#(
  parameter int LINES          = 64,
  parameter int EXTERNAL_LINES = 32,
  parameter int MAX_TARGETS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_op,
  input  logic [5:0]  in_line,
  input  logic [2:0]  in_target_index,
  input  logic [63:0] in_mask,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_ok,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_target,
  output logic [5:0]  out_line_res,
  output logic [2:0]  out_route_value,
  output logic [31:0] out_enabled_now,
  output logic [31:0] out_pending_now,
  output logic [31:0] out_active_now,
  output logic        out_last
);

  ird_cmd_t cmd;
  ird_sts_t sts;

  ird_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ird_datapath #(
    .LINES          (LINES),
    .EXTERNAL_LINES (EXTERNAL_LINES),
    .MAX_TARGETS    (MAX_TARGETS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_line         (in_line),
    .in_target_index (in_target_index),
    .in_mask         (in_mask),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_ok          (out_ok),
    .out_kind        (out_kind),
    .out_target      (out_target),
    .out_line_res    (out_line_res),
    .out_route_value (out_route_value),
    .out_enabled_now (out_enabled_now),
    .out_pending_now (out_pending_now),
    .out_active_now  (out_active_now),
    .out_last        (out_last)
  );

endmodule
